// File: sv/acfp_pkg.sv
// Shared types, constants and the nibble decoder for the ASCII hex to CAN frame parser.
package acfp_pkg;

    localparam int STORE_CHARS_DEF = 22;
    // Number of character positions a frame can reference: 4 id, 1 pad, 1 length, 16 data.
    localparam int FRAME_CHARS     = 22;
    localparam int MIN_FRAME_CHARS = 6;
    localparam int DATA_BYTES      = 8;
    localparam int QUEUE_DEPTH     = 2;

    localparam logic [7:0] CH_START = 8'h3E;  // '>'
    localparam logic [7:0] CH_END   = 8'h3C;  // '<'
    localparam logic [7:0] CH_ACK   = 8'h41;  // 'A'
    localparam logic [7:0] CH_SENT  = 8'h54;  // 'T'
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CASE_FOLD_MASK = 8'hDF;
    localparam logic [3:0] MAX_LEN  = 4'd8;

    typedef enum logic [1:0] {
        OP_ECHO,
        OP_ACK,
        OP_FRAME
    } op_t;

    typedef struct packed {
        op_t         op;
        logic [7:0]  ch;
        logic [15:0] id;
        logic [3:0]  len;
        logic [63:0] data;
    } cmd_t;

    // Returns {bad, nibble}: hex digits of either case, or raw codes 0x00-0x0F.
    function automatic logic [4:0] nib_decode(input logic [7:0] c);
        logic [7:0] m;
        logic [7:0] d;
        m = (c > 8'h39) ? (c & CASE_FOLD_MASK) : c;
        d = 8'h00;
        if (m inside {[8'h30:8'h39]}) begin
            d = m - 8'h30;
            return {1'b0, d[3:0]};
        end
        else if (m inside {[8'h41:8'h46]}) begin
            d = m - 8'h37;
            return {1'b0, d[3:0]};
        end
        else if (m < 8'h10) begin
            return {1'b0, m[3:0]};
        end
        else begin
            return {1'b1, m[3:0]};
        end
    endfunction

endpackage

// File: sv/acfp_front.sv
// Front end: takes received bytes, tracks reception, stores nibbles and decodes frames.
module acfp_front #(
    parameter int STORE_CHARS = acfp_pkg::STORE_CHARS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [7:0]           rx_char,
    output logic                 q_push,
    output acfp_pkg::cmd_t       q_cmd,
    input  logic                 q_full
);

    localparam int CNT_W = $clog2(STORE_CHARS + 1);
    localparam int IDX_W = $clog2(STORE_CHARS);

    logic             receiving_reg, receiving_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [3:0]       store_reg [STORE_CHARS];
    logic             store_we;
    logic [4:0]       dec;
    logic             accept;

    logic [3:0]       nib_ext [acfp_pkg::FRAME_CHARS];
    logic [3:0]       frame_len;
    logic [15:0]      frame_id;
    logic [63:0]      frame_data;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign q_push   = accept;
    assign dec      = acfp_pkg::nib_decode(rx_char);

    // Positions past the store read as nibble zero.
    for (genvar i = 0; i < acfp_pkg::FRAME_CHARS; i++) begin : g_ext
        if (i < STORE_CHARS) begin : g_in
            assign nib_ext[i] = store_reg[i];
        end
        else begin : g_out
            assign nib_ext[i] = 4'h0;
        end
    end

    assign frame_len = nib_ext[5];
    assign frame_id  = {nib_ext[0], nib_ext[1], nib_ext[2], nib_ext[3]};

    always_comb
    begin
        frame_data = '0;
        for (int k = 0; k < acfp_pkg::DATA_BYTES; k++) begin
            if (4'(k) < frame_len) begin
                frame_data[8*k +: 8] = {nib_ext[6 + 2*k], nib_ext[7 + 2*k]};
            end
        end
    end

    always_comb
    begin
        receiving_next = receiving_reg;
        count_next     = count_reg;
        store_we       = 1'b0;
        q_cmd.op       = acfp_pkg::OP_ECHO;
        q_cmd.ch       = rx_char;
        q_cmd.id       = frame_id;
        q_cmd.len      = frame_len;
        q_cmd.data     = frame_data;
        if (rx_char == acfp_pkg::CH_START) begin
            q_cmd.op       = acfp_pkg::OP_ACK;
            count_next     = '0;
            receiving_next = 1'b1;
        end
        else if (receiving_reg) begin
            if (rx_char == acfp_pkg::CH_END) begin
                // short frame: keep receiving, keep the count
                if (count_reg >= CNT_W'(acfp_pkg::MIN_FRAME_CHARS)) begin
                    receiving_next = 1'b0;
                    if (frame_len <= acfp_pkg::MAX_LEN) begin
                        q_cmd.op = acfp_pkg::OP_FRAME;
                    end
                end
            end
            else if (dec[4]) begin
                receiving_next = 1'b0;
            end
            else if (count_reg >= CNT_W'(STORE_CHARS)) begin
                receiving_next = 1'b0;
            end
            else begin
                store_we   = 1'b1;
                count_next = count_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            receiving_reg <= 1'b0;
            count_reg     <= '0;
            for (int i = 0; i < STORE_CHARS; i++) begin
                store_reg[i] <= 4'h0;
            end
        end
        else if (accept) begin
            receiving_reg <= receiving_next;
            count_reg     <= count_next;
            if (store_we) begin
                store_reg[count_reg[IDX_W-1:0]] <= dec[3:0];
            end
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(STORE_CHARS))
        else $error("character count beyond store size");

endmodule

// File: sv/acfp_fifo.sv
// Short command queue between the front end and the result sequencer.
module acfp_fifo #(
    parameter int DEPTH = acfp_pkg::QUEUE_DEPTH
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  acfp_pkg::cmd_t push_data,
    output logic           full,
    input  logic           pop,
    output acfp_pkg::cmd_t pop_data,
    output logic           not_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    acfp_pkg::cmd_t   mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (!full || pop))
        else $error("queue write while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> not_empty)
        else $error("queue read while empty");

endmodule

// File: sv/acfp_back.sv
// Result sequencer: expands one queued command into one, two or five results.
module acfp_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_valid,
    input  acfp_pkg::cmd_t q_cmd,
    output logic           q_pop,
    output logic           out_valid,
    input  logic           out_ready,
    output logic           result_kind,
    output logic [7:0]     tx_char,
    output logic [15:0]    frame_id,
    output logic [3:0]     frame_len,
    output logic [63:0]    frame_data,
    output logic           last_result
);

    localparam logic [2:0] STEP_ECHO   = 3'd0;
    localparam logic [2:0] STEP_SECOND = 3'd1;
    localparam logic [2:0] STEP_CR     = 3'd2;
    localparam logic [2:0] STEP_LF     = 3'd3;
    localparam logic [2:0] STEP_FRAME  = 3'd4;

    logic [2:0]  step_reg, step_next;
    logic        out_valid_reg, out_valid_next;
    logic        kind_reg, last_reg;
    logic [7:0]  char_reg;
    logic [15:0] id_reg;
    logic [3:0]  len_reg;
    logic [63:0] data_reg;

    logic        load;
    logic        is_last;
    logic        r_kind;
    logic [7:0]  r_char;
    logic [15:0] r_id;
    logic [3:0]  r_len;
    logic [63:0] r_data;

    assign load  = q_valid && (!out_valid_reg || out_ready);
    assign q_pop = load && is_last;

    always_comb
    begin
        case (q_cmd.op)
            acfp_pkg::OP_ECHO:  is_last = 1'b1;
            acfp_pkg::OP_ACK:   is_last = (step_reg == STEP_SECOND);
            acfp_pkg::OP_FRAME: is_last = (step_reg == STEP_FRAME);
            default:            is_last = 1'b1;
        endcase
    end

    always_comb
    begin
        r_kind = 1'b0;
        r_char = 8'h00;
        r_id   = 16'h0000;
        r_len  = 4'h0;
        r_data = 64'h0;
        case (step_reg)
            STEP_ECHO:   r_char = q_cmd.ch;
            STEP_SECOND: r_char = (q_cmd.op == acfp_pkg::OP_ACK) ? acfp_pkg::CH_ACK
                                                                 : acfp_pkg::CH_SENT;
            STEP_CR:     r_char = acfp_pkg::CH_CR;
            STEP_LF:     r_char = acfp_pkg::CH_LF;
            STEP_FRAME:
            begin
                r_kind = 1'b1;
                r_id   = q_cmd.id;
                r_len  = q_cmd.len;
                r_data = q_cmd.data;
            end
            default:     r_char = 8'h00;
        endcase
    end

    always_comb
    begin
        step_next      = step_reg;
        out_valid_next = out_valid_reg;
        if (load) begin
            step_next      = is_last ? STEP_ECHO : step_reg + 3'd1;
            out_valid_next = 1'b1;
        end
        else if (out_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            step_reg      <= STEP_ECHO;
            out_valid_reg <= 1'b0;
        end
        else begin
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load) begin
            kind_reg <= r_kind;
            char_reg <= r_char;
            id_reg   <= r_id;
            len_reg  <= r_len;
            data_reg <= r_data;
            last_reg <= is_last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign result_kind = kind_reg;
    assign tx_char     = char_reg;
    assign frame_id    = id_reg;
    assign frame_len   = len_reg;
    assign frame_data  = data_reg;
    assign last_result = last_reg;

    a_head_held: assert property (@(posedge clk) disable iff (!rst_n)
        (step_reg != STEP_ECHO) |-> q_valid)
        else $error("command left the queue mid-sequence");

    a_frame_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && kind_reg) |-> last_reg)
        else $error("CAN frame result not marked last");

endmodule

// File: sv/ascii_hex_to_can_frame_parser.sv
// Top level of the ASCII hex serial to CAN frame parser.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+------------------------------------------
//  input   | in        | in_valid / in_ready  | rx_char
//  output  | out       | out_valid / out_ready| result_kind, tx_char, frame_id, frame_len,
//          |           |                      | frame_data, last_result
//
// Cycles: the front end takes one byte per clock while the command queue has room.
// The sequencer sends one result per clock while out_ready allows, so a byte yields one
// result (echo), two (echo and 'A') or five (echo, 'T', CR, LF, frame); the sequencer's
// output register sets the sustained rate.
// Reset: rst_n clears reception, the character count and the nibble store at once.
// Stalls: out_ready low holds the output register; the queue then fills and in_ready
// drops, while the front end keeps its reception state untouched.
module ascii_hex_to_can_frame_parser #(
    parameter int STORE_CHARS = acfp_pkg::STORE_CHARS_DEF,
    parameter int QUEUE_DEPTH = acfp_pkg::QUEUE_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  rx_char,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        result_kind,
    output logic [7:0]  tx_char,
    output logic [15:0] frame_id,
    output logic [3:0]  frame_len,
    output logic [63:0] frame_data,
    output logic        last_result
);

    // Command transfer from the front end into the queue
    logic           q_push;
    acfp_pkg::cmd_t q_push_cmd;
    logic           q_full;

    // Command transfer from the queue into the sequencer
    logic           q_pop;
    acfp_pkg::cmd_t q_head_cmd;
    logic           q_not_empty;

    // Front end: classifies each byte, updates reception and, at '<', decodes the
    // stored nibbles into id, length and data in the same cycle.
    acfp_front #(
        .STORE_CHARS (STORE_CHARS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .rx_char  (rx_char),
        .q_push   (q_push),
        .q_cmd    (q_push_cmd),
        .q_full   (q_full)
    );

    // Decouples byte intake from result delivery so either side can stall.
    acfp_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_head_cmd),
        .not_empty (q_not_empty)
    );

    // Sequencer: walks the head command through its results, one per transfer.
    acfp_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_not_empty),
        .q_cmd       (q_head_cmd),
        .q_pop       (q_pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .result_kind (result_kind),
        .tx_char     (tx_char),
        .frame_id    (frame_id),
        .frame_len   (frame_len),
        .frame_data  (frame_data),
        .last_result (last_result)
    );

endmodule

// File: tb/ascii_hex_to_can_frame_parser_checker.sv
// Reply predictor and scoreboard for the ASCII hex to CAN frame parser.
module ascii_hex_to_can_frame_parser_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [7:0]  rx_char,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic        result_kind,
    input  logic [7:0]  tx_char,
    input  logic [15:0] frame_id,
    input  logic [3:0]  frame_len,
    input  logic [63:0] frame_data,
    input  logic        last_result,
    output int          fail_count,
    output int          pending,
    output int          reply_count,
    output int          frame_count
);

    localparam int STORE_CHARS = acfp_pkg::STORE_CHARS_DEF;

    typedef struct {
        logic        kind;
        logic [7:0]  ch;
        logic [15:0] id;
        logic [3:0]  len;
        logic [63:0] data;
        logic        is_last;
    } reply_t;

    // predicted parser state
    logic        rx_active;
    logic [4:0]  stored_chars;
    logic [7:0]  char_mem [STORE_CHARS];

    reply_t replies_due [$];

    // values 0-15 are nibbles, anything above is not
    function automatic logic [7:0] hex_value(input logic [7:0] c);
        logic [7:0] f;
        f = (c > 8'h39) ? (c & acfp_pkg::CASE_FOLD_MASK) : c;
        if (f >= "0" && f <= "9")
            return f - "0";
        if (f >= "A" && f <= "F")
            return f - "A" + 8'd10;
        return f;
    endfunction

    function automatic logic [3:0] stored_nibble(input int idx);
        logic [7:0] v;
        if (idx >= STORE_CHARS)
            return 4'h0;
        v = hex_value(char_mem[idx]);
        return v[3:0];
    endfunction

    function automatic reply_t serial_reply(input logic [7:0] c);
        reply_t r;
        r.kind    = 1'b0;
        r.ch      = c;
        r.id      = '0;
        r.len     = '0;
        r.data    = '0;
        r.is_last = 1'b0;
        return r;
    endfunction

    task automatic predict_replies(input logic [7:0] c);
        reply_t     r [5];
        int         n;
        logic [3:0] len;
        logic [63:0] data;
        n = 0;
        r[n++] = serial_reply(c);
        if (c == acfp_pkg::CH_START) begin
            r[n++] = serial_reply(acfp_pkg::CH_ACK);
            stored_chars = '0;
            rx_active = 1'b1;
        end
        else if (rx_active) begin
            if (c == acfp_pkg::CH_END) begin
                // short frames are ignored and reception goes on
                if (stored_chars >= acfp_pkg::MIN_FRAME_CHARS) begin
                    len = stored_nibble(5);
                    rx_active = 1'b0;
                    if (len <= acfp_pkg::MAX_LEN) begin
                        data = '0;
                        for (int k = 0; k < len; k++)
                            data[8*k +: 8] = {stored_nibble(6 + 2*k), stored_nibble(7 + 2*k)};
                        r[n++] = serial_reply(acfp_pkg::CH_SENT);
                        r[n++] = serial_reply(acfp_pkg::CH_CR);
                        r[n++] = serial_reply(acfp_pkg::CH_LF);
                        r[n] = serial_reply(8'h00);
                        r[n].kind = 1'b1;
                        r[n].id = {stored_nibble(0), stored_nibble(1),
                                   stored_nibble(2), stored_nibble(3)};
                        r[n].len = len;
                        r[n].data = data;
                        n++;
                    end
                end
            end
            else if (hex_value(c) > 8'd15 || stored_chars >= STORE_CHARS) begin
                rx_active = 1'b0;
            end
            else begin
                char_mem[stored_chars] = c;
                stored_chars = stored_chars + 5'd1;
            end
        end
        r[n-1].is_last = 1'b1;
        for (int i = 0; i < n; i++)
            replies_due.push_back(r[i]);
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        reply_t want;
        if (!rst_n) begin
            rx_active = 1'b0;
            stored_chars = '0;
            for (int i = 0; i < STORE_CHARS; i++)
                char_mem[i] = 8'h00;
            replies_due.delete();
            fail_count = 0;
            reply_count = 0;
            frame_count = 0;
            pending = 0;
        end
        else begin
            if (in_valid && in_ready)
                predict_replies(rx_char);
            if (out_valid && out_ready) begin
                if (replies_due.size() == 0) begin
                    $error("unexpected result: kind %0d char 0x%0h id 0x%0h",
                           result_kind, tx_char, frame_id);
                    fail_count++;
                end
                else begin
                    want = replies_due.pop_front();
                    check_field("result_kind", want.kind, result_kind);
                    check_field("tx_char", want.ch, tx_char);
                    check_field("frame_id", want.id, frame_id);
                    check_field("frame_len", want.len, frame_len);
                    check_field("frame_data", want.data, frame_data);
                    check_field("last_result", want.is_last, last_result);
                    reply_count++;
                    if (want.kind)
                        frame_count++;
                end
            end
            pending = replies_due.size();
        end
    end

endmodule

// File: tb/ascii_hex_to_can_frame_parser_test.sv
// Stimulus and verdict for the ASCII hex to CAN frame parser.
module ascii_hex_to_can_frame_parser_test;

    // Random traffic runs in three equal thirds with different idle mixes.
    localparam int PHASE_BYTES = 125;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  rx_char;
    logic        out_valid;
    logic        out_ready;
    logic        result_kind;
    logic [7:0]  tx_char;
    logic [15:0] frame_id;
    logic [3:0]  frame_len;
    logic [63:0] frame_data;
    logic        last_result;

    int fail_count;
    int pending;
    int reply_count;
    int frame_count;

    // idle rates in percent of cycles, changed per phase
    int send_idle_pct;
    int recv_idle_pct;
    int sent_count;

    ascii_hex_to_can_frame_parser dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .rx_char     (rx_char),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .result_kind (result_kind),
        .tx_char     (tx_char),
        .frame_id    (frame_id),
        .frame_len   (frame_len),
        .frame_data  (frame_data),
        .last_result (last_result)
    );

    ascii_hex_to_can_frame_parser_checker reply_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .rx_char     (rx_char),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .result_kind (result_kind),
        .tx_char     (tx_char),
        .frame_id    (frame_id),
        .frame_len   (frame_len),
        .frame_data  (frame_data),
        .last_result (last_result),
        .fail_count  (fail_count),
        .pending     (pending),
        .reply_count (reply_count),
        .frame_count (frame_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop, far beyond the slowest legal run.
    initial
    begin
        #2000000;
        $display("ascii_hex_to_can_frame_parser test failed");
        $finish;
    end

    // Receiver: ready is redrawn every falling edge from the current idle rate.
    always @(negedge clk)
        out_ready <= ($urandom_range(99) >= recv_idle_pct);

    // One byte transfer. Called at a falling edge, returns at a falling edge.
    // Valid only drops when an idle gap is taken, so it never toggles within
    // one step.
    task automatic send_byte(input logic [7:0] c);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        rx_char  <= c;
        do
            @(posedge clk);
        while (!in_ready);
        sent_count++;
        @(negedge clk);
    endtask

    // Stop sending and wait until every predicted reply has been checked.
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
    endtask

    // Any of the accepted spellings of a nibble: raw code, digit, upper or
    // lower case letter.
    function automatic logic [7:0] nib_char(input logic [3:0] v);
        case ($urandom_range(3))
            0: return {4'h0, v};
            1: return (v < 10) ? 8'("0" + v) : 8'("A" + v - 10);
            2: return (v < 10) ? 8'("0" + v) : 8'("a" + v - 10);
            default: return (v < 10) ? 8'("0" + v) : 8'("A" + v - 10);
        endcase
    endfunction

    // A byte that is neither a nibble nor a frame delimiter.
    function automatic logic [7:0] junk_char();
        logic [7:0] c;
        c = 8'($urandom_range(8'h10, 8'hFF));
        while ((c >= "0" && c <= "9") || ((c & acfp_pkg::CASE_FOLD_MASK) >= "A" &&
               (c & acfp_pkg::CASE_FOLD_MASK) <= "F" && c > 8'h39) ||
               c == acfp_pkg::CH_END || c == acfp_pkg::CH_START)
            c = 8'($urandom_range(8'h10, 8'hFF));
        return c;
    endfunction

    // Mostly a proper frame with random content; sometimes the data run is
    // short (stale store bytes fill in), long, or the length is out of range.
    // A premature close may appear before six characters are in.
    task automatic send_frame();
        int         len;
        int         data_chars;
        int         early_at;
        logic [3:0] head [6];
        for (int i = 0; i < 6; i++)
            head[i] = 4'($urandom_range(15));
        len = ($urandom_range(99) < 85) ? $urandom_range(8) : $urandom_range(9, 15);
        head[5] = 4'(len);
        case ($urandom_range(9))
            0, 1:    data_chars = $urandom_range(16);
            9:       data_chars = $urandom_range(2 * ((len > 8) ? 8 : len), 16);
            default: data_chars = 2 * ((len > 8) ? 8 : len);
        endcase
        early_at = ($urandom_range(99) < 20) ? $urandom_range(5) : -1;
        send_byte(acfp_pkg::CH_START);
        for (int i = 0; i < 6; i++) begin
            if (i == early_at)
                send_byte(acfp_pkg::CH_END);
            send_byte(nib_char(head[i]));
        end
        for (int i = 0; i < data_chars; i++)
            send_byte(nib_char(4'($urandom_range(15))));
        send_byte(acfp_pkg::CH_END);
    endtask

    // Fill the store to the brim, then overflow it or close the frame.
    task automatic send_full_store();
        send_byte(acfp_pkg::CH_START);
        for (int i = 0; i < acfp_pkg::STORE_CHARS_DEF; i++)
            send_byte(nib_char(4'($urandom_range(15))));
        if ($urandom_range(1))
            send_byte(nib_char(4'($urandom_range(15))));
        send_byte(acfp_pkg::CH_END);
    endtask

    // A frame broken by a bad byte or a restart, followed by some leftovers.
    task automatic send_broken();
        send_byte(acfp_pkg::CH_START);
        repeat ($urandom_range(8))
            send_byte(nib_char(4'($urandom_range(15))));
        send_byte(($urandom_range(99) < 30) ? acfp_pkg::CH_START : junk_char());
        repeat ($urandom_range(7))
            send_byte(nib_char(4'($urandom_range(15))));
        send_byte(acfp_pkg::CH_END);
    endtask

    task automatic send_random_sequence();
        int pick;
        pick = $urandom_range(99);
        if (pick < 60)
            send_frame();
        else if (pick < 70)
            send_full_store();
        else if (pick < 85)
            send_broken();
        else
            repeat ($urandom_range(1, 6))
                send_byte(8'($urandom_range(255)));
    endtask

    initial
    begin
        int base;
        in_valid      = 1'b0;
        rx_char       = 8'h00;
        out_ready     = 1'b0;
        send_idle_pct = 16;
        recv_idle_pct = 76;
        sent_count    = 0;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: field extremes and bytes outside reception.
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(acfp_pkg::CH_END);
        // Close right after the start: too short, reception continues.
        send_byte(acfp_pkg::CH_START);
        send_byte(acfp_pkg::CH_END);
        // Mixed-case id, raw code as length, odd data run so the last data
        // byte picks up a stale store character.
        send_byte("1");
        send_byte("a");
        send_byte("2");
        send_byte("F");
        send_byte("0");
        send_byte(8'h02);
        send_byte("b");
        send_byte("C");
        send_byte(8'h0E);
        send_byte(acfp_pkg::CH_END);
        // Length nibble of nine: frame dropped, echo only.
        send_byte(acfp_pkg::CH_START);
        repeat (5)
            send_byte("0");
        send_byte("9");
        send_byte(acfp_pkg::CH_END);
        wait_drained();

        // Random traffic: receiver-heavy idling, then sender-heavy, then none.
        // Each phase ends with the sender holding off until all replies are in.
        base = sent_count;
        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 16 : (phase == 1) ? 76 : 0;
            recv_idle_pct = (phase == 0) ? 76 : (phase == 1) ? 16 : 0;
            while (sent_count < base + (phase + 1) * PHASE_BYTES)
                send_random_sequence();
            wait_drained();
        end

        // Leave room for any stray reply to show up.
        repeat (20) @(negedge clk);

        $display("sent %0d bytes; checked %0d replies, %0d of them CAN frames",
                 sent_count, reply_count, frame_count);
        $display("covered short, oversize, aborted, stale-data and store-full frames");
        if (fail_count == 0 && pending == 0)
            $display("ascii_hex_to_can_frame_parser test passed");
        else
            $display("ascii_hex_to_can_frame_parser test failed");
        $finish;
    end

endmodule

// File: filelist.f
sv/acfp_pkg.sv
sv/acfp_front.sv
sv/acfp_fifo.sv
sv/acfp_back.sv
sv/ascii_hex_to_can_frame_parser.sv
tb/ascii_hex_to_can_frame_parser_checker.sv
tb/ascii_hex_to_can_frame_parser_test.sv
